@@ rtl/core/b64d_pkg.sv @@
// Shared types, constants and the alphabet lookup for the base64 stream decoder.
// No dependencies; imported by b64d_decode and base64_stream_decoder.
package b64d_pkg;

    // Lookup codes for characters that are not alphabet sextets
    localparam logic [7:0] CODE_INVALID = 8'hFF;
    localparam logic [7:0] CODE_PAD     = 8'hFE;

    // Characters with a special meaning
    localparam logic [7:0] CHAR_PAD = 8'h3D;  // '='
    localparam logic [7:0] CHAR_SP  = 8'h20;  // ' '
    localparam logic [7:0] CHAR_TAB = 8'h09;  // '\t'
    localparam logic [7:0] CHAR_LF  = 8'h0A;  // '\n'
    localparam logic [7:0] CHAR_CR  = 8'h0D;  // '\r'

    // Group positions
    localparam logic [1:0] POS_0 = 2'd0;
    localparam logic [1:0] POS_1 = 2'd1;
    localparam logic [1:0] POS_2 = 2'd2;
    localparam logic [1:0] POS_3 = 2'd3;

    // Result queue sizing: one item writes up to three results
    localparam int MAX_RES  = 3;
    localparam int QDEPTH   = 6;
    localparam int QCNT_W   = $clog2(QDEPTH + 1);

    // Decoder state carried between characters
    typedef struct packed {
        logic [1:0]      pos;
        logic [2:0][5:0] sext;
        logic            third_pad;
        logic            err;
    } dec_state_t;

    // One result beat
    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       done;
        logic       error;
        logic       last;
    } res_t;

    // Map a text byte to its sextet, or to CODE_PAD / CODE_INVALID
    function automatic logic [7:0] sextet_of(input logic [7:0] c);
        logic [7:0] code;
        code = CODE_INVALID;
        if (c >= 8'h41 && c <= 8'h5A)
            code = c - 8'h41;
        else if (c >= 8'h61 && c <= 8'h7A)
            code = c - 8'h61 + 8'd26;
        else if (c >= 8'h30 && c <= 8'h39)
            code = c - 8'h30 + 8'd52;
        else if (c == 8'h2B)
            code = 8'd62;
        else if (c == 8'h2F)
            code = 8'd63;
        else if (c == CHAR_PAD)
            code = CODE_PAD;
        return code;
    endfunction

endpackage

@@ rtl/core/b64d_decode.sv @@
// Combinational decode of one input beat against the current group state.
// Depends on b64d_pkg; gives the next state and up to three result beats.
module b64d_decode (
    input  logic [7:0]                       in_char,
    input  logic                             end_of_input,
    input  b64d_pkg::dec_state_t             st,
    output b64d_pkg::dec_state_t             st_next,
    output logic [1:0]                       res_cnt,
    output b64d_pkg::res_t [b64d_pkg::MAX_RES-1:0] res
);
    import b64d_pkg::*;

    logic [7:0] code;
    logic       is_pad;
    logic       is_ws;
    logic       bad;
    logic       err;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;

    // Byte assembly from held sextets and the incoming one
    assign byte0 = {st.sext[0], st.sext[1][5:4]};
    assign byte1 = {st.sext[1][3:0], st.sext[2][5:2]};
    assign byte2 = {st.sext[2][1:0], code[5:0]};

    assign code   = sextet_of(in_char);
    assign is_pad = (code == CODE_PAD);
    assign is_ws  = (in_char == CHAR_LF) || (in_char == CHAR_CR) ||
                    (in_char == CHAR_SP) || (in_char == CHAR_TAB);
    assign bad    = (code == CODE_INVALID) ||
                    (is_pad && (st.pos == POS_0 || st.pos == POS_1)) ||
                    (st.pos == POS_3 && st.third_pad && !is_pad);

    always_comb
    begin
        st_next = st;
        res_cnt = 2'd0;
        res     = '0;
        err     = st.err;
        if (end_of_input)
        begin
            // Flush the partial group, then close with a status beat
            if (!st.err)
            begin
                unique case (st.pos)
                    POS_1: err = 1'b1;
                    POS_2:
                    begin
                        res[0].data  = byte0;
                        res[0].valid = 1'b1;
                    end
                    POS_3:
                    begin
                        if (st.third_pad)
                            err = 1'b1;
                        else
                        begin
                            res[0].data  = byte0;
                            res[0].valid = 1'b1;
                            res[1].data  = byte1;
                            res[1].valid = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            if (res[1].valid)
            begin
                res[2].done  = 1'b1;
                res[2].error = err;
                res[2].last  = 1'b1;
                res_cnt      = 2'd3;
            end
            else if (res[0].valid)
            begin
                res[1].done  = 1'b1;
                res[1].error = err;
                res[1].last  = 1'b1;
                res_cnt      = 2'd2;
            end
            else
            begin
                res[0].done  = 1'b1;
                res[0].error = err;
                res[0].last  = 1'b1;
                res_cnt      = 2'd1;
            end
            st_next = '0;
        end
        else if (!is_ws && !st.err)
        begin
            if (bad)
            begin
                // Latch the error and report it once
                st_next.err  = 1'b1;
                res[0].error = 1'b1;
                res[0].last  = 1'b1;
                res_cnt      = 2'd1;
            end
            else if (st.pos != POS_3)
            begin
                // Hold the sextet and advance the group
                unique case (st.pos)
                    POS_0: st_next.sext[0] = code[5:0];
                    POS_1: st_next.sext[1] = code[5:0];
                    default: st_next.sext[2] = is_pad ? 6'd0 : code[5:0];
                endcase
                st_next.third_pad = st.third_pad | is_pad;
                st_next.pos       = st.pos + 2'd1;
            end
            else
            begin
                // Group complete: emit one to three bytes
                res[0].data  = byte0;
                res[0].valid = 1'b1;
                if (st.third_pad)
                begin
                    res[0].last = 1'b1;
                    res_cnt     = 2'd1;
                end
                else if (is_pad)
                begin
                    res[1].data  = byte1;
                    res[1].valid = 1'b1;
                    res[1].last  = 1'b1;
                    res_cnt      = 2'd2;
                end
                else
                begin
                    res[1].data  = byte1;
                    res[1].valid = 1'b1;
                    res[2].data  = byte2;
                    res[2].valid = 1'b1;
                    res[2].last  = 1'b1;
                    res_cnt      = 2'd3;
                end
                st_next.pos       = POS_0;
                st_next.sext      = '0;
                st_next.third_pad = 1'b0;
            end
        end
    end

endmodule

@@ rtl/core/base64_stream_decoder.sv @@
// Top level of the base64 stream decoder: group state, decode and result queue.
// Depends on b64d_pkg and b64d_decode.
//
//   channel | signals                                            | beat
//   --------+----------------------------------------------------+------------------
//   in      | in_valid, in_ready, in_char, end_of_input          | one text char/EOI
//   out     | out_valid, out_ready, out_byte, byte_valid,        | one result
//           | stream_done, decode_error, run_last                |
//
// An input beat is decoded in the cycle it is accepted; its results enter a
// six-entry result queue whose head drives the output ports from registers.
// One character per cycle is taken as long as the queue has room for three
// results after this cycle's pop; a full group of four yields at most three.
// A stalled output holds the input off once more than three results wait.
// Reset clears the group state, the latched error and the queue.
module base64_stream_decoder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_char,
    input  logic       end_of_input,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       stream_done,
    output logic       decode_error,
    output logic       run_last
);
    import b64d_pkg::*;

    dec_state_t               st_reg;
    dec_state_t               st_next;
    dec_state_t               dec_st;
    logic [1:0]               res_cnt;
    res_t [MAX_RES-1:0]       res;
    res_t [QDEPTH-1:0]        q_reg;
    res_t [QDEPTH-1:0]        q_next;
    logic [QCNT_W-1:0]        cnt_reg;
    logic [QCNT_W-1:0]        cnt_next;
    logic [QCNT_W-1:0]        base;
    logic [QCNT_W-1:0]        off;
    logic                     pop;
    logic                     take;

    b64d_decode u_decode (
        .in_char      (in_char),
        .end_of_input (end_of_input),
        .st           (st_reg),
        .st_next      (dec_st),
        .res_cnt      (res_cnt),
        .res          (res)
    );

    // Handshakes
    assign out_valid = (cnt_reg != '0);
    assign pop       = out_valid && out_ready;
    assign base      = cnt_reg - QCNT_W'(pop);
    assign in_ready  = (base <= QCNT_W'(QDEPTH - MAX_RES));
    assign take      = in_valid && in_ready;

    // Advance the group state on an accepted beat
    assign st_next = take ? dec_st : st_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= '0;
        else
            st_reg <= st_next;
    end

    // Drop the head on pop, append new results behind the survivors
    always_comb
    begin
        q_next   = q_reg;
        off      = '0;
        cnt_next = base;
        for (int j = 0; j < QDEPTH; j++)
        begin
            if (pop && j < QDEPTH - 1)
                q_next[j] = q_reg[j + 1];
            off = QCNT_W'(j) - base;
            if (take && QCNT_W'(j) >= base && off < QCNT_W'(res_cnt))
                q_next[j] = res[off[1:0]];
        end
        if (take)
            cnt_next = base + QCNT_W'(res_cnt);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    // Drive the output beat from the queue head
    assign out_byte     = q_reg[0].data;
    assign byte_valid   = q_reg[0].valid;
    assign stream_done  = q_reg[0].done;
    assign decode_error = q_reg[0].error;
    assign run_last     = q_reg[0].last;

endmodule
